FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros for the checker file mrtu_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// shared types, constants and the crc-16 byte update for the modbus receiver
// ----------------------------------------------------------------------------
package mrtu_pkg;

    localparam int          FRAME_CAPACITY = 128;
    localparam int          RES_DEPTH      = 4;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;

    typedef enum logic [2:0] {
        ST_NOTHING = 3'd0,
        ST_STORED  = 3'd1,
        ST_GOOD    = 3'd2,
        ST_BAD     = 3'd3,
        ST_DROPPED = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [6:0]  byte_index;
        logic [7:0]  stored_byte;
        logic [7:0]  frame_length;
        logic        for_us;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    vld;
        logic    two;
        t_result res0;
        t_result res1;
    } t_push;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/mrtu_core.sv
// ----------------------------------------------------------------------------
// mrtu_core
// input register, frame state and one-pass result generation
// ----------------------------------------------------------------------------
module mrtu_core #(
    parameter int FRAME_CAPACITY = mrtu_pkg::FRAME_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_op,
    input  logic [7:0]      i_data_byte,
    input  logic            i_gap_before,
    input  logic            i_cfg_valid,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_room,
    output mrtu_pkg::t_push o_push
);
    import mrtu_pkg::*;

    localparam int CW = $clog2(FRAME_CAPACITY + 1);

    logic          r_vld;
    logic          r_op;
    logic [7:0]    r_byte;
    logic          r_gap;
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [7:0]    r_first;
    logic [7:0]    r_slave;

    logic [CW-1:0] n_count;
    logic [15:0]   n_crc;
    logic [7:0]    n_first;

    logic          fire;
    logic          load;
    logic          end_frm;
    logic          good;
    logic [CW-1:0] cnt0;
    logic [15:0]   crc0;
    logic [7:0]    first0;
    logic [8:0]    cnt_ext;
    logic [8:0]    cnt0_ext;
    t_result       end_res;
    t_result       byte_res;
    t_result       none_res;

    assign fire       = r_vld && i_room;
    assign o_in_stall = r_vld && !i_room;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op   <= i_op;
            r_byte <= i_data_byte;
            r_gap  <= i_gap_before;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_first <= 8'h00;
            r_slave <= SLAVE_ADDR_RST;
        end else begin
            if (fire) begin
                r_count <= n_count;
                r_crc   <= n_crc;
                r_first <= n_first;
            end
            if (i_cfg_valid) begin
                r_slave <= i_cfg_data;
            end
        end
    end

    always_comb begin
        end_frm = (r_count != '0) && (r_op || r_gap);
        good    = (r_count >= CW'(2)) && (r_crc == 16'h0000);
        cnt_ext = 9'(r_count);

        end_res              = '0;
        end_res.status       = good ? ST_GOOD : ST_BAD;
        end_res.frame_length = cnt_ext[7:0];
        end_res.for_us       = good && (r_first == r_slave);

        none_res        = '0;
        none_res.status = ST_NOTHING;

        cnt0     = end_frm ? '0 : r_count;
        crc0     = end_frm ? CRC_INIT : r_crc;
        first0   = end_frm ? 8'h00 : r_first;
        cnt0_ext = 9'(cnt0);

        byte_res = '0;
        if (cnt0 < CW'(FRAME_CAPACITY)) begin
            byte_res.status      = ST_STORED;
            byte_res.byte_index  = cnt0_ext[6:0];
            byte_res.stored_byte = r_byte;
            n_count              = cnt0 + CW'(1);
            n_crc                = crc16_byte(crc0, r_byte);
            n_first              = (cnt0 == '0) ? r_byte : first0;
        end else begin
            byte_res.status = ST_DROPPED;
            n_count         = cnt0;
            n_crc           = crc0;
            n_first         = first0;
        end

        o_push     = '0;
        o_push.vld = fire;
        if (r_op) begin
            n_count          = cnt0;
            n_crc            = crc0;
            n_first          = first0;
            o_push.res0      = end_frm ? end_res : none_res;
            o_push.res0.last = 1'b1;
        end else if (end_frm) begin
            o_push.two       = 1'b1;
            o_push.res0      = end_res;
            o_push.res1      = byte_res;
            o_push.res1.last = 1'b1;
        end else begin
            o_push.res0      = byte_res;
            o_push.res0.last = 1'b1;
        end
    end

endmodule

FILE: hdl/mrtu_rslt_fifo.sv
// ----------------------------------------------------------------------------
// mrtu_rslt_fifo
// small result queue: one or two results in a cycle, one out unless stalled
// ----------------------------------------------------------------------------
module mrtu_rslt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrtu_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mrtu_pkg::t_result o_head
);
    import mrtu_pkg::*;

    localparam int PW = $clog2(RES_DEPTH);

    t_result       r_mem [RES_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    logic          pop;
    logic [PW:0]   push_n;
    logic [PW-1:0] wp1;

    assign o_out_valid = (r_cnt != '0);
    assign o_room      = (r_cnt <= (PW+1)'(RES_DEPTH - 2));
    assign pop         = o_out_valid && !i_out_stall;
    assign o_head      = r_mem[r_rp];
    assign wp1         = r_wp + PW'(1);

    always_comb begin
        if (!i_push.vld) begin
            push_n = '0;
        end else if (i_push.two) begin
            push_n = (PW+1)'(2);
        end else begin
            push_n = (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push_n[PW-1:0];
            r_rp  <= r_rp + PW'(pop);
            r_cnt <= r_cnt + push_n - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wp] <= i_push.res0;
            if (i_push.two) begin
                r_mem[wp1] <= i_push.res1;
            end
        end
    end

endmodule

FILE: hdl/modbus_rtu_frame_receiver.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver
// throughput: one request per cycle while the queue has room; a request that
//   ends a frame and stores a byte gives two results, so the single output
//   port sets the sustained rate; results are registered in the result queue
// reset: synchronous active-low, empties the frame and the result queue and
//   sets slave_address to 1
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver #(
    parameter int FRAME_CAPACITY = mrtu_pkg::FRAME_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_gap_before,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [6:0] o_byte_index,
    output logic [7:0] o_stored_byte,
    output logic [7:0] o_frame_length,
    output logic       o_for_us,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import mrtu_pkg::*;

    t_push   push;
    logic    room;
    t_result head;

    assign o_cfg_ready = 1'b1;

    mrtu_core #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_gap_before(i_gap_before),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    mrtu_rslt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room     (room),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_head     (head)
    );

    assign o_status       = head.status;
    assign o_byte_index   = head.byte_index;
    assign o_stored_byte  = head.stored_byte;
    assign o_frame_length = head.frame_length;
    assign o_for_us       = head.for_us;
    assign o_last         = head.last;

endmodule

FILE: hdl/mrtu_checker.sv
// ----------------------------------------------------------------------------
// mrtu_checker
// port-level checks for the modbus receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrtu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic [6:0] o_byte_index,
    input logic [7:0] o_stored_byte,
    input logic [7:0] o_frame_length,
    input logic       o_for_us,
    input logic       o_last
);
    import mrtu_pkg::*;

    `ASSERT_CLK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_last), "stalled result changed")
    `ASSERT_CLK(a_for_us_good, o_out_valid && o_for_us |-> o_status == ST_GOOD, "for_us on a frame that is not good")
    `ASSERT_CLK(a_idx_zero, o_out_valid && o_status != ST_STORED |-> o_byte_index == 7'd0 && o_stored_byte == 8'd0, "byte fields set on a non-stored result")
    `ASSERT_CLK(a_stall_known, !$isunknown(o_in_stall) && !$isunknown(o_frame_length), "unknown stall or length")
    `ASSERT_CLK_ALWAYS(a_rst_empty, $past(!i_rst_n) |-> !o_out_valid, "result offered right after reset")

endmodule

bind modbus_rtu_frame_receiver mrtu_checker u_mrtu_checker (.*);

FILE: tb/mrtu_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_frame_checker
// watches the request, result and address-write channels of the modbus
// receiver, keeps its own frame count, crc and lead byte, works out the
// reports each accepted request should give and compares every accepted
// result with the oldest report still due
// ----------------------------------------------------------------------------
module mrtu_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_gap_before,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_status,
    input  logic [6:0] i_byte_index,
    input  logic [7:0] i_stored_byte,
    input  logic [7:0] i_frame_length,
    input  logic       i_for_us,
    input  logic       i_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_good_frames,
    output int         o_bad_frames,
    output int         o_addressed_frames,
    output int         o_drops
);
    import mrtu_pkg::*;

    logic [7:0]  node_addr;
    int unsigned frame_bytes;
    logic [15:0] frame_crc;
    logic [7:0]  lead_byte;
    t_result     due_reports[$];
    t_result     got;

    // lsb-first crc-16, one data bit per step
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic t_result close_frame();
        t_result r;
        logic    good;
        good           = (frame_bytes >= 2) && (frame_crc == 16'h0000);
        r              = '0;
        r.status       = good ? ST_GOOD : ST_BAD;
        r.frame_length = frame_bytes[7:0];
        r.for_us       = good && (lead_byte == node_addr);
        if (good) o_good_frames++;
        else o_bad_frames++;
        if (r.for_us) o_addressed_frames++;
        frame_bytes = 0;
        frame_crc   = CRC_INIT;
        lead_byte   = '0;
        return r;
    endfunction

    task automatic frame_rx_step(input logic op, input logic [7:0] b, input logic gap);
        t_result r [2];
        int      n;
        n    = 0;
        r[0] = '0;
        r[1] = '0;
        if (op) begin
            if (frame_bytes != 0) r[0] = close_frame();
            else r[0].status = ST_NOTHING;
            n = 1;
        end else begin
            if (gap && frame_bytes != 0) begin
                r[0] = close_frame();
                n    = 1;
            end
            if (frame_bytes < FRAME_CAPACITY) begin
                if (frame_bytes == 0) lead_byte = b;
                frame_crc        = crc_fold(frame_crc, b);
                r[n].status      = ST_STORED;
                r[n].byte_index  = frame_bytes[6:0];
                r[n].stored_byte = b;
                frame_bytes++;
            end else begin
                r[n].status = ST_DROPPED;
                o_drops++;
            end
            n++;
        end
        r[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) due_reports.push_back(r[k]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_addr   = SLAVE_ADDR_RST;
            frame_bytes = 0;
            frame_crc   = CRC_INIT;
            lead_byte   = '0;
            due_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) node_addr = i_cfg_data;
            if (i_in_valid && !i_in_stall) frame_rx_step(i_op, i_data_byte, i_gap_before);
            if (i_out_valid && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    $error("result with nothing due: status %0d", i_status);
                    o_errors++;
                end else begin
                    got = due_reports.pop_front();
                    check_field("status", 8'(got.status), 8'(i_status));
                    check_field("byte_index", 8'(got.byte_index), 8'(i_byte_index));
                    check_field("stored_byte", got.stored_byte, i_stored_byte);
                    check_field("frame_length", got.frame_length, i_frame_length);
                    check_field("for_us", 8'(got.for_us), 8'(i_for_us));
                    check_field("last", 8'(got.last), 8'(i_last));
                end
            end
        end
        o_pending = due_reports.size();
    end

endmodule

FILE: tb/modbus_rtu_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_tb
// drives byte and timeout requests into the modbus rtu receiver: a short
// directed opening, then random frames with good and corrupted crc, noise
// bytes and timeouts under several node addresses, with random idling on
// both channels, a long result hold-off and a capacity overflow
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_tb;
    import mrtu_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 180;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [7:0] data_byte;
    logic       gap_before;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [6:0] byte_index;
    logic [7:0] stored_byte;
    logic [7:0] frame_length;
    logic       for_us;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int errors;
    int pending;
    int n_good;
    int n_bad;
    int n_addressed;
    int n_drops;
    int sent;
    int cycles;
    bit quiet;
    bit hold_req;

    logic [7:0] own;
    logic [7:0] frame_buf[$];

    modbus_rtu_frame_receiver i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (op),
        .i_data_byte    (data_byte),
        .i_gap_before   (gap_before),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_byte_index   (byte_index),
        .o_stored_byte  (stored_byte),
        .o_frame_length (frame_length),
        .o_for_us       (for_us),
        .o_last         (last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    mrtu_frame_checker i_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_op               (op),
        .i_data_byte        (data_byte),
        .i_gap_before       (gap_before),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_status           (status),
        .i_byte_index       (byte_index),
        .i_stored_byte      (stored_byte),
        .i_frame_length     (frame_length),
        .i_for_us           (for_us),
        .i_last             (last),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .o_errors           (errors),
        .o_pending          (pending),
        .o_good_frames      (n_good),
        .o_bad_frames       (n_bad),
        .o_addressed_frames (n_addressed),
        .o_drops            (n_drops)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_len;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall_len = quiet ? 0 : pick_gap();
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic send_req(input logic req_op, input logic [7:0] b, input logic g);
        int idle;
        idle = quiet ? 0 : pick_gap();
        if (idle > 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= req_op;
        data_byte  <= b;
        gap_before <= g;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_timeout();
        send_req(1'b1, 8'($urandom), 1'($urandom));
    endtask

    // append the crc low byte first, optionally flip one bit anywhere
    task automatic seal_frame(input bit corrupt);
        logic [15:0] c;
        int          pos;
        c = CRC_INIT;
        foreach (frame_buf[k]) begin
            c ^= {8'h00, frame_buf[k]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        if (corrupt) begin
            pos = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
    endtask

    task automatic make_frame(input logic [7:0] addr, input int len, input bit corrupt);
        frame_buf.delete();
        frame_buf.push_back(addr);
        repeat (len) frame_buf.push_back(8'($urandom));
        seal_frame(corrupt);
    endtask

    task automatic send_frame(input logic lead_gap);
        foreach (frame_buf[k]) send_req(1'b0, frame_buf[k], (k == 0) ? lead_gap : 1'b0);
    endtask

    function automatic logic [7:0] frame_addr();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return own;
            5, 6:          return 8'h00;
            7:             return 8'hFF;
            default:       return 8'($urandom);
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_addr(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        own = v;
    endtask

    task automatic run_directed();
        send_timeout();
        frame_buf = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A};
        seal_frame(1'b0);
        send_frame(1'b0);
        frame_buf = '{8'hFF, 8'h00};
        seal_frame(1'b1);
        send_frame(1'b1);
        send_timeout();
        send_timeout();
        // crc-only frame of two bytes
        frame_buf.delete();
        seal_frame(1'b0);
        send_frame(1'b1);
        send_req(1'b0, 8'h00, 1'b1);
        send_req(1'b0, 8'h80, 1'b1);
        send_timeout();
    endtask

    task automatic run_random(input int p);
        int first;
        int r;
        int len;
        first = sent;
        if (p == 1) begin
            // full store with a good crc, then a few dropped bytes
            make_frame(own, FRAME_CAPACITY - 3, 1'b0);
            send_frame(1'b1);
            repeat ($urandom_range(1, 3)) send_req(1'b0, 8'($urandom), 1'b0);
        end
        if (p == 4) begin
            make_frame(frame_addr(), $urandom_range(FRAME_CAPACITY - 1, FRAME_CAPACITY + 7),
                       1'($urandom));
            send_frame(1'b1);
        end
        while (sent - first < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
                make_frame(frame_addr(), len, $urandom_range(0, 3) == 0);
                send_frame($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 2) == 0) send_timeout();
            end else if (r < 85) begin
                send_timeout();
            end else begin
                send_req(1'b0, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        logic [7:0] addr_plan [PHASES];
        in_valid   <= 1'b0;
        op         <= 1'b0;
        data_byte  <= 8'h00;
        gap_before <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= 8'h00;
        rst_n      <= 1'b0;
        sent     = 0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        own      = SLAVE_ADDR_RST;
        addr_plan = '{SLAVE_ADDR_RST, 8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            // phase 0 runs on the reset address
            if (p != 0) begin
                drain();
                write_addr(addr_plan[p]);
            end
            quiet = (p == 3);
            if (p == 2) hold_req = 1'b1;
            run_random(p);
        end
        drain();
        $display("%0d requests under %0d node addresses, incl. a full store and overflow",
                 sent, PHASES);
        $display("frames: %0d good (%0d addressed here), %0d bad; %0d bytes dropped",
                 n_good, n_addressed, n_bad, n_drops);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
